// File: sv/reb_pkg.sv
// Shared types and constants for the rotary encoder button event block.
`default_nettype none

package reb_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 8'd1;

    localparam logic [TICK_W-1:0] LONG_PRESS_RESET    = 16'd10000;
    localparam logic [TICK_W-1:0] DOUBLE_WINDOW_RESET = 16'd1500;

    localparam logic [1:0] ROT_EV_NONE  = 2'd0;
    localparam logic [1:0] ROT_EV_LEFT  = 2'd1;
    localparam logic [1:0] ROT_EV_RIGHT = 2'd2;

    localparam logic [1:0] BTN_EV_NONE   = 2'd0;
    localparam logic [1:0] BTN_EV_CLICK  = 2'd1;
    localparam logic [1:0] BTN_EV_DOUBLE = 2'd2;
    localparam logic [1:0] BTN_EV_LONG   = 2'd3;

    typedef logic [TICK_W-1:0] t_ticks;

    typedef struct packed {
        logic ch_a;
        logic ch_b;
        logic key_level;
    } t_sample;

    typedef struct packed {
        logic [1:0] rot_event;
        logic [1:0] button_event;
    } t_event;

endpackage

`default_nettype wire

// File: sv/reb_if.sv
// Valid/ready channel interfaces for samples, events and configuration writes.
`default_nettype none

interface reb_in_if;
    logic valid;
    logic ready;
    logic ch_a;
    logic ch_b;
    logic key_level;

    modport source (output valid, output ch_a, output ch_b, output key_level, input ready);
    modport sink   (input valid, input ch_a, input ch_b, input key_level, output ready);
endinterface

interface reb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] rot_event;
    logic [1:0] button_event;

    modport source (output valid, output rot_event, output button_event, input ready);
    modport sink   (input valid, input rot_event, input button_event, output ready);
endinterface

interface reb_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/rotary_encoder_button_events.sv
// Rotary encoder step and button click/double/long event detector.
// Takes one sample transaction per clock while input ready is high and returns
// one event transaction per sample: the sample lands in an input register,
// the rotation and button machines and both tick timers update as it moves to
// the result register. When the result is stalled, one more sample waits in
// the input register; after that input ready drops until the result is taken.
// Timer periods (register 0 long press, register 1 double window) are written
// through the configuration channel, which is always ready.
`default_nettype none

module rotary_encoder_button_events
    import reb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    reb_in_if.sink      i_in,
    reb_out_if.source   o_out,
    reb_cfg_if.sink     i_cfg
);

    typedef enum logic [1:0] {
        ROT_IDLE  = 2'd0,
        ROT_LEFT  = 2'd1,
        ROT_RIGHT = 2'd2
    } t_rot_phase;

    typedef enum logic [1:0] {
        KEY_IDLE   = 2'd0,
        KEY_FIRST  = 2'd1,
        KEY_WAIT   = 2'd2,
        KEY_SECOND = 2'd3
    } t_key_phase;

    t_ticks     r_long_ticks;
    t_ticks     r_double_ticks;
    t_rot_phase r_rot,    n_rot;
    t_key_phase r_key,    n_key;
    t_ticks     r_long,   n_long;
    t_ticks     r_double, n_double;
    logic       r_in_valid;
    t_sample    r_in;
    logic       r_out_valid;
    t_event     r_out,    n_out;

    logic   advance;
    logic   step;
    t_ticks long_inc;
    t_ticks double_inc;
    logic   long_done;
    logic   double_done;
    logic   pressed;

    assign advance     = !r_out_valid || o_out.ready;
    assign step        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.rot_event    = r_out.rot_event;
    assign o_out.button_event = r_out.button_event;

    assign long_inc    = (r_long == '1) ? r_long : r_long + t_ticks'(1);
    assign double_inc  = (r_double == '1) ? r_double : r_double + t_ticks'(1);
    assign long_done   = long_inc >= r_long_ticks;
    assign double_done = double_inc >= r_double_ticks;
    assign pressed     = !r_in.key_level;

    always_comb begin
        n_rot    = r_rot;
        n_key    = r_key;
        n_long   = long_inc;
        n_double = double_inc;
        n_out    = '{rot_event: ROT_EV_NONE, button_event: BTN_EV_NONE};

        unique case (r_rot)
            ROT_LEFT, ROT_RIGHT: begin
                if (r_in.ch_a && r_in.ch_b) begin
                    n_out.rot_event = (r_rot == ROT_LEFT) ? ROT_EV_LEFT : ROT_EV_RIGHT;
                    n_rot           = ROT_IDLE;
                end
            end
            default: begin
                n_rot = ROT_IDLE;
                if (r_in.ch_a != r_in.ch_b) begin
                    n_rot = r_in.ch_a ? ROT_RIGHT : ROT_LEFT;
                end
            end
        endcase

        unique case (r_key)
            KEY_IDLE: begin
                if (pressed) begin
                    n_key    = KEY_FIRST;
                    n_long   = '0;
                    n_double = '0;
                end
            end
            KEY_FIRST: begin
                if (!pressed) begin
                    if (long_done) begin
                        n_key              = KEY_IDLE;
                        n_out.button_event = BTN_EV_LONG;
                    end else if (double_done) begin
                        n_key              = KEY_IDLE;
                        n_out.button_event = BTN_EV_CLICK;
                    end else begin
                        n_key              = KEY_WAIT;
                        n_out.button_event = BTN_EV_CLICK;
                    end
                end
            end
            KEY_WAIT: begin
                if (double_done) begin
                    n_key = KEY_IDLE;
                end
                if (pressed) begin
                    n_key  = KEY_SECOND;
                    n_long = '0;
                end
            end
            default: begin
                if (!pressed) begin
                    if (long_done) begin
                        n_out.button_event = BTN_EV_LONG;
                    end else if (!double_done) begin
                        n_out.button_event = BTN_EV_DOUBLE;
                    end else begin
                        n_out.button_event = BTN_EV_CLICK;
                    end
                    n_key = KEY_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= LONG_PRESS_RESET;
            r_double_ticks <= DOUBLE_WINDOW_RESET;
            r_rot          <= ROT_IDLE;
            r_key          <= KEY_IDLE;
            r_long         <= '0;
            r_double       <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_LONG_PRESS) begin
                    r_long_ticks <= i_cfg.data;
                end else if (i_cfg.index == REG_DOUBLE_WINDOW) begin
                    r_double_ticks <= i_cfg.data;
                end
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_rot    <= n_rot;
                r_key    <= n_key;
                r_long   <= n_long;
                r_double <= n_double;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= '{ch_a: i_in.ch_a, ch_b: i_in.ch_b, key_level: i_in.key_level};
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    a_step_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed sample did not produce a result");

    a_idle_no_button_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_key == KEY_IDLE) |=> (r_out.button_event == BTN_EV_NONE))
        else $error("button event reported from idle");

    a_double_only_from_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_key != KEY_SECOND) |=> (r_out.button_event != BTN_EV_DOUBLE))
        else $error("double click without second press");

    a_press_restarts_timers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_key == KEY_IDLE && !r_in.key_level)
        |=> (r_long == '0 && r_double == '0 && r_key == KEY_FIRST))
        else $error("first press did not restart timers");

endmodule

`default_nettype wire

// File: sim/reb_checker.sv
// Event predictor and scoreboard for the rotary encoder button event block.
module reb_checker
    import reb_pkg::*;
(
    input  wire i_clk,
    input  wire i_rst_n,
    reb_in_if   i_in,
    reb_out_if  i_out,
    reb_cfg_if  i_cfg,
    output int  o_fail_count,
    output int  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ROT_IDLE, ROT_LEFT, ROT_RIGHT, ROT_SPARE} e_rot;
    typedef enum logic [1:0] {KEY_IDLE, KEY_FIRST, KEY_WAIT, KEY_SECOND} e_key;

    t_ticks long_period;
    t_ticks double_period;
    t_ticks long_age;
    t_ticks double_age;
    e_rot   rot_st;
    e_key   key_st;
    t_event expected_events[$];
    int     fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_ticks age_up(t_ticks v);
        return (v == '1) ? v : t_ticks'(v + 1'b1);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        fail_count++;
        $display("%0t MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    task automatic predict_event(input t_sample s, output t_event ev);
        logic pressed;
        logic long_hit;
        logic double_hit;
        ev.rot_event    = ROT_EV_NONE;
        ev.button_event = BTN_EV_NONE;
        long_age   = age_up(long_age);
        double_age = age_up(double_age);
        pressed    = !s.key_level;
        long_hit   = long_age >= long_period;
        double_hit = double_age >= double_period;

        if (rot_st == ROT_LEFT || rot_st == ROT_RIGHT) begin
            if (s.ch_a && s.ch_b) begin
                ev.rot_event = (rot_st == ROT_LEFT) ? ROT_EV_LEFT : ROT_EV_RIGHT;
                rot_st = ROT_IDLE;
            end
        end else if (s.ch_a != s.ch_b) begin
            rot_st = s.ch_a ? ROT_RIGHT : ROT_LEFT;
        end else begin
            rot_st = ROT_IDLE;
        end

        case (key_st)
            KEY_IDLE: begin
                if (pressed) begin
                    key_st     = KEY_FIRST;
                    long_age   = '0;
                    double_age = '0;
                end
            end
            KEY_FIRST: begin
                if (!pressed) begin
                    if (long_hit) begin
                        key_st = KEY_IDLE;
                        ev.button_event = BTN_EV_LONG;
                    end else if (double_hit) begin
                        key_st = KEY_IDLE;
                        ev.button_event = BTN_EV_CLICK;
                    end else begin
                        key_st = KEY_WAIT;
                        ev.button_event = BTN_EV_CLICK;
                    end
                end
            end
            KEY_WAIT: begin
                // a press wins over window expiry in the same tick
                if (pressed) begin
                    key_st   = KEY_SECOND;
                    long_age = '0;
                end else if (double_hit) begin
                    key_st = KEY_IDLE;
                end
            end
            default: begin
                if (!pressed) begin
                    if (long_hit)
                        ev.button_event = BTN_EV_LONG;
                    else if (!double_hit)
                        ev.button_event = BTN_EV_DOUBLE;
                    else
                        ev.button_event = BTN_EV_CLICK;
                    key_st = KEY_IDLE;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_sample s;
        t_event  ev;
        t_event  want;
        if (!i_rst_n) begin
            long_period   = LONG_PRESS_RESET;
            double_period = DOUBLE_WINDOW_RESET;
            long_age      = '0;
            double_age    = '0;
            rot_st        = ROT_IDLE;
            key_st        = KEY_IDLE;
            expected_events.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_LONG_PRESS)
                    long_period = i_cfg.data;
                else if (i_cfg.index == REG_DOUBLE_WINDOW)
                    double_period = i_cfg.data;
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event transaction", 1, 0);
                end else begin
                    want = expected_events.pop_front();
                    if (i_out.rot_event !== want.rot_event)
                        report_mismatch("rot_event", int'(i_out.rot_event),
                                        int'(want.rot_event));
                    if (i_out.button_event !== want.button_event)
                        report_mismatch("button_event", int'(i_out.button_event),
                                        int'(want.button_event));
                end
            end
            if (i_in.valid && i_in.ready) begin
                s.ch_a      = i_in.ch_a;
                s.ch_b      = i_in.ch_b;
                s.key_level = i_in.key_level;
                predict_event(s, ev);
                expected_events.push_back(ev);
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fail_count;
    end
endmodule

// File: sim/tb.sv
// Top-level testbench: clock, reset, sample and register stimulus, verdict.
module tb;
    import reb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

    logic   i_clk;
    logic   i_rst_n;
    int     send_idle_pct = 34;
    int     recv_idle_pct = 77;
    int     fail_count;
    int     pending;
    int     stall_cycles = 0;
    t_ticks cur_long;
    t_ticks cur_double;
    int     enc_pos = 0;
    int     enc_dir = 1;
    logic   key_lvl = 1'b1;
    int     key_run = 0;

    reb_in_if  in_ch();
    reb_out_if out_ch();
    reb_cfg_if cfg_ch();

    rotary_encoder_button_events dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    reb_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic a, input logic b, input logic k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.ch_a      <= a;
        in_ch.ch_b      <= b;
        in_ch.key_level <= k;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    task automatic hold(input logic a, input logic b, input logic k, input int n);
        repeat (n) send_sample(a, b, k);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_ticks value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
    endtask

    task automatic set_periods(input t_ticks lp, input t_ticks dp, input logic spare);
        drain();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_DOUBLE_WINDOW, dp);
        if (spare)
            write_reg(REG_SPARE, t_ticks'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_long   = lp;
        cur_double = dp;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        drain();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic int pick_run(t_ticks period);
        int cap;
        cap = (period > 60) ? 60 : int'(period);
        case ($urandom_range(4))
            0: return 1;
            1: return (cap > 1) ? cap - 1 : 1;
            2: return (cap > 0) ? cap : 1;
            3: return cap + 1;
            default: return $urandom_range(2 * cap + 2, 1);
        endcase
    endfunction

    // quadrature walk with noise, button runs sized around the timer periods
    task automatic random_samples(input int n);
        int   r;
        logic a;
        logic b;
        repeat (n) begin
            r = $urandom_range(9);
            if (r == 0)
                enc_dir = -enc_dir;
            if (r < 5)
                enc_pos = (enc_pos + enc_dir + 4) % 4;
            case (enc_pos)
                0: begin a = 1'b1; b = 1'b1; end
                1: begin a = 1'b0; b = 1'b1; end
                2: begin a = 1'b0; b = 1'b0; end
                default: begin a = 1'b1; b = 1'b0; end
            endcase
            if (r == 9) begin
                a = 1'($urandom_range(1));
                b = 1'($urandom_range(1));
            end
            if (key_run == 0) begin
                key_lvl = ~key_lvl;
                key_run = pick_run(key_lvl ? cur_double : cur_long);
            end
            key_run--;
            send_sample(a, b, key_lvl);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.ch_a      = 1'b1;
        in_ch.ch_b      = 1'b1;
        in_ch.key_level = 1'b1;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        cur_long        = LONG_PRESS_RESET;
        cur_double      = DOUBLE_WINDOW_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // quick click at reset periods, leaves the button waiting
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        set_periods(16'd6, 16'd4, 1'b1);
        // double click
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        // left step, right step, both low from idle
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);
        // long press
        hold(1'b1, 1'b1, 1'b0, 6);
        send_sample(1'b1, 1'b1, 1'b1);
        // click after window expired while held
        hold(1'b1, 1'b1, 1'b0, 4);
        send_sample(1'b1, 1'b1, 1'b1);
        // window expires while waiting
        send_sample(1'b1, 1'b1, 1'b0);
        hold(1'b1, 1'b1, 1'b1, 4);
        // press on the expiry tick still counts as second press
        send_sample(1'b1, 1'b1, 1'b0);
        hold(1'b1, 1'b1, 1'b1, 3);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        // zero periods
        set_periods(16'd0, 16'd4, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        set_periods(16'd3, 16'd0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);

        set_periods(16'd5, 16'd3, 1'b0);
        random_samples(70);
        set_periods(16'd1, 16'd1, 1'b0);
        random_samples(60);

        set_idling(77, 34);
        set_periods(16'd20, 16'd8, 1'b0);
        random_samples(70);
        set_periods(16'd0, 16'd0, 1'b0);
        random_samples(40);
        set_periods(16'hFFFF, 16'd1, 1'b0);
        random_samples(50);

        set_idling(0, 0);
        set_periods(16'd3, 16'hFFFF, 1'b0);
        random_samples(60);
        set_periods(16'd12, 16'd6, 1'b1);
        random_samples(30);
        drain();
        random_samples(30);
        hold(1'b1, 1'b1, 1'b1, 20);

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
sv/reb_pkg.sv
sv/reb_if.sv
sv/rotary_encoder_button_events.sv
sim/reb_checker.sv
sim/tb.sv
